>>> rtl/bsl_pkg.sv
package bsl_pkg;

    // list geometry
    localparam int CAPACITY = 16;
    localparam int DATA_W   = 32;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    // operation codes
    localparam logic [2:0] OP_APPEND     = 3'd0;
    localparam logic [2:0] OP_PREPEND    = 3'd1;
    localparam logic [2:0] OP_POP_END    = 3'd2;
    localparam logic [2:0] OP_POP_FRONT  = 3'd3;
    localparam logic [2:0] OP_FIND       = 3'd4;
    localparam logic [2:0] OP_REMOVE     = 3'd5;
    localparam logic [2:0] OP_INS_BEFORE = 3'd6;
    localparam logic [2:0] OP_STATUS     = 3'd7;

    // status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_EMPTY    = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    // per-cell load control
    typedef struct packed {
        logic ld_new;
        logic ld_left;
        logic ld_right;
    } t_cell_ctl;

endpackage

>>> rtl/bsl_cell.sv
module bsl_cell (
    input  logic                        i_clk,
    input  bsl_pkg::t_cell_ctl          i_ctl,
    input  logic [bsl_pkg::DATA_W-1:0]  i_new_code,
    input  logic [bsl_pkg::DATA_W-1:0]  i_new_pay,
    input  logic [bsl_pkg::DATA_W-1:0]  i_left_code,
    input  logic [bsl_pkg::DATA_W-1:0]  i_left_pay,
    input  logic [bsl_pkg::DATA_W-1:0]  i_right_code,
    input  logic [bsl_pkg::DATA_W-1:0]  i_right_pay,
    input  logic [bsl_pkg::DATA_W-1:0]  i_target,
    output logic [bsl_pkg::DATA_W-1:0]  o_code,
    output logic [bsl_pkg::DATA_W-1:0]  o_pay,
    output logic                        o_match
);

    logic [bsl_pkg::DATA_W-1:0] r_code;
    logic [bsl_pkg::DATA_W-1:0] r_pay;

    // entry storage: new word, shift from lower or from upper neighbor
    always_ff @(posedge i_clk) begin
        if (i_ctl.ld_new) begin
            r_code <= i_new_code;
            r_pay  <= i_new_pay;
        end else if (i_ctl.ld_left) begin
            r_code <= i_left_code;
            r_pay  <= i_left_pay;
        end else if (i_ctl.ld_right) begin
            r_code <= i_right_code;
            r_pay  <= i_right_pay;
        end
    end

    // local code compare
    assign o_match = (r_code == i_target);
    assign o_code  = r_code;
    assign o_pay   = r_pay;

endmodule

>>> rtl/bounded_sequential_list_core.sv
// a request word is captured together with the code compare in all cells, then the
// execute state does position select and shift along the cell chain and registers the
// result word; a new word is taken only back in idle, so one word is handled at a time
// a result waiting in the output register stalls the shift cycle, not the accept
// reset (synchronous, active low) empties the list; cell contents stay undefined
module bounded_sequential_list_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // item_code [31:0], item_payload [63:32], target_code [95:64]
    input  logic [95:0] i_s_axis_tdata,
    // op [2:0]
    input  logic [2:0]  i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // out_code [31:0], out_payload [63:32], entry_count [68:64], is_full [69],
    // is_empty [70], zero [71]
    output logic [71:0] o_m_axis_tdata,
    // status [1:0]
    output logic [1:0]  o_m_axis_tuser
);

    localparam int CAP = bsl_pkg::CAPACITY;
    localparam int DW  = bsl_pkg::DATA_W;
    localparam int CW  = bsl_pkg::CNT_W;
    localparam int IW  = bsl_pkg::IDX_W;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic            r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic [2:0]      r_op;
    logic [DW-1:0]   r_icode;
    logic [DW-1:0]   r_ipay;
    logic [CAP-1:0]  r_match;
    logic            r_out_valid;
    logic [71:0]     r_out_data, n_out_data;
    logic [1:0]      r_out_user, n_out_user;

    logic [DW-1:0]   w_code  [CAP];
    logic [DW-1:0]   w_pay   [CAP];
    logic [CAP-1:0]  w_match;
    bsl_pkg::t_cell_ctl w_ctl [CAP];

    logic            w_in_acc;
    logic            w_out_free;
    logic            w_exec;

    assign w_in_acc        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free      = !r_out_valid || i_m_axis_tready;
    assign w_exec          = (r_state == S_EXEC) && w_out_free;
    assign o_s_axis_tready = (r_state == S_IDLE);

    // cell chain
    genvar g;
    generate
        for (g = 0; g < CAP; g++) begin : g_cell
            logic [DW-1:0] w_lc, w_lp, w_rc, w_rp;
            if (g == 0) begin : g_lo
                assign w_lc = '0;
                assign w_lp = '0;
            end else begin : g_lo_n
                assign w_lc = w_code[g-1];
                assign w_lp = w_pay[g-1];
            end
            if (g == CAP - 1) begin : g_hi
                assign w_rc = '0;
                assign w_rp = '0;
            end else begin : g_hi_n
                assign w_rc = w_code[g+1];
                assign w_rp = w_pay[g+1];
            end
            bsl_cell u_cell (
                .i_clk        (i_clk),
                .i_ctl        (w_ctl[g]),
                .i_new_code   (r_icode),
                .i_new_pay    (r_ipay),
                .i_left_code  (w_lc),
                .i_left_pay   (w_lp),
                .i_right_code (w_rc),
                .i_right_pay  (w_rp),
                .i_target     (i_s_axis_tdata[95:64]),
                .o_code       (w_code[g]),
                .o_pay        (w_pay[g]),
                .o_match      (w_match[g])
            );
        end
    endgenerate

    // position select, cell control and result build
    always_comb begin
        logic [CAP-1:0] mv;
        logic           first_hit, last_hit;
        logic [IW-1:0]  first_pos, last_pos;
        logic           do_ins, do_del, do_rd;
        logic [CW-1:0]  ins_pos, del_pos;
        logic [IW-1:0]  rd_pos;
        logic [1:0]     st;
        logic           full, empty;
        logic [DW-1:0]  oc, opay;

        full  = (r_count == CW'(CAP));
        empty = (r_count == '0);
        for (int i = 0; i < CAP; i++) begin
            mv[i] = r_match[i] && (CW'(i) < r_count);
        end

        // lowest matching position
        first_hit = 1'b0;
        first_pos = '0;
        for (int i = CAP - 1; i >= 0; i--) begin
            if (mv[i]) begin
                first_hit = 1'b1;
                first_pos = IW'(i);
            end
        end
        // highest matching position
        last_hit = 1'b0;
        last_pos = '0;
        for (int i = 0; i < CAP; i++) begin
            if (mv[i]) begin
                last_hit = 1'b1;
                last_pos = IW'(i);
            end
        end

        do_ins  = 1'b0;
        do_del  = 1'b0;
        do_rd   = 1'b0;
        ins_pos = '0;
        del_pos = '0;
        rd_pos  = '0;
        st      = bsl_pkg::ST_OK;
        n_count = r_count;

        case (r_op)
            bsl_pkg::OP_APPEND: begin
                if (full) begin
                    st = bsl_pkg::ST_FULL;
                end else begin
                    do_ins  = 1'b1;
                    ins_pos = r_count;
                end
            end
            bsl_pkg::OP_PREPEND: begin
                if (full) begin
                    st = bsl_pkg::ST_FULL;
                end else begin
                    do_ins = 1'b1;
                end
            end
            bsl_pkg::OP_POP_END: begin
                if (empty) begin
                    st = bsl_pkg::ST_EMPTY;
                end else begin
                    do_rd   = 1'b1;
                    rd_pos  = IW'(r_count - CW'(1));
                    n_count = r_count - CW'(1);
                end
            end
            bsl_pkg::OP_POP_FRONT: begin
                if (empty) begin
                    st = bsl_pkg::ST_EMPTY;
                end else begin
                    do_rd  = 1'b1;
                    do_del = 1'b1;
                end
            end
            bsl_pkg::OP_FIND: begin
                if (first_hit) begin
                    do_rd  = 1'b1;
                    rd_pos = first_pos;
                end else begin
                    st = bsl_pkg::ST_NOTFOUND;
                end
            end
            bsl_pkg::OP_REMOVE: begin
                if (empty) begin
                    st = bsl_pkg::ST_EMPTY;
                end else if (last_hit) begin
                    do_rd   = 1'b1;
                    do_del  = 1'b1;
                    rd_pos  = last_pos;
                    del_pos = CW'(last_pos);
                end else begin
                    st = bsl_pkg::ST_NOTFOUND;
                end
            end
            bsl_pkg::OP_INS_BEFORE: begin
                if (full) begin
                    st = bsl_pkg::ST_FULL;
                end else if (empty) begin
                    st = bsl_pkg::ST_EMPTY;
                end else if (first_hit) begin
                    do_ins  = 1'b1;
                    ins_pos = CW'(first_pos);
                end else begin
                    st = bsl_pkg::ST_NOTFOUND;
                end
            end
            default: begin
            end
        endcase

        if (do_ins) begin
            n_count = r_count + CW'(1);
        end
        if (do_del) begin
            n_count = r_count - CW'(1);
        end

        // per-cell load: open a gap or close one
        for (int i = 0; i < CAP; i++) begin
            w_ctl[i].ld_new   = w_exec && do_ins && (CW'(i) == ins_pos);
            w_ctl[i].ld_left  = w_exec && do_ins && (CW'(i) > ins_pos)
                                && (CW'(i) <= r_count);
            w_ctl[i].ld_right = w_exec && do_del && (CW'(i) >= del_pos)
                                && ((CW'(i) + CW'(1)) < r_count);
        end

        // removed or found entry
        oc   = do_rd ? w_code[rd_pos] : '0;
        opay = do_rd ? w_pay[rd_pos]  : '0;

        n_out_user = st;
        n_out_data = {1'b0, (n_count == '0), (n_count == CW'(CAP)), 5'(n_count),
                      opay, oc};
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_exec) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (w_in_acc) n_state = S_EXEC;
            S_EXEC:  if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // word capture and compare snapshot
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_op    <= i_s_axis_tuser;
            r_icode <= i_s_axis_tdata[31:0];
            r_ipay  <= i_s_axis_tdata[63:32];
            r_match <= w_match;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (w_exec) begin
            r_out_data <= n_out_data;
            r_out_user <= n_out_user;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAP))
        else $error("list count beyond capacity");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_exec |=> r_count == $past(r_count))
        else $error("count changed outside an execute cycle");

    a_count_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> o_m_axis_tdata[68:64] == 5'(r_count))
        else $error("result count differs from list count");

    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(o_m_axis_tdata[69] && o_m_axis_tdata[70]))
        else $error("result flags full and empty together");
`endif

endmodule

>>> tb/tb_bounded_sequential_list_core.sv
`timescale 1ns / 1ps

module tb_bounded_sequential_list_core;

    localparam int RANDOM_ITEMS   = 2000;
    localparam int QUIET_TAIL     = 250;
    localparam int HOLD_AT        = 300;
    localparam int HOLD_CYCLES    = 120;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 10;
    localparam int PRINT_CAP      = 50;

    // expected result word of one list operation
    typedef struct {
        logic [1:0]  status;
        logic [31:0] code;
        logic [31:0] payload;
        logic [4:0]  entries;
        logic        full;
        logic        empty;
    } t_list_result;

    // mirror of the list contents plus the queue of results still owed
    class t_list_mirror;
        logic [31:0]  entry_code[bsl_pkg::CAPACITY];
        logic [31:0]  entry_payload[bsl_pkg::CAPACITY];
        int unsigned  entry_total;
        t_list_result owed_results[$];
        int unsigned  mismatches;
        int unsigned  checked;
        int unsigned  status_seen[4];
        int unsigned  full_seen;

        function new();
            entry_total = 0;
            mismatches  = 0;
            checked     = 0;
            full_seen   = 0;
            foreach (status_seen[i]) status_seen[i] = 0;
        endfunction

        // open a hole at pos and drop the new entry in
        function void insert_at(int unsigned pos, logic [31:0] code, logic [31:0] payload);
            for (int unsigned i = entry_total; i > pos; i--) begin
                entry_code[i]    = entry_code[i - 1];
                entry_payload[i] = entry_payload[i - 1];
            end
            entry_code[pos]    = code;
            entry_payload[pos] = payload;
            entry_total++;
        endfunction

        // close up the entry at pos
        function void remove_at(int unsigned pos);
            for (int unsigned i = pos; i + 1 < entry_total; i++) begin
                entry_code[i]    = entry_code[i + 1];
                entry_payload[i] = entry_payload[i + 1];
            end
            entry_total--;
        endfunction

        // lowest matching position, entry_total when none
        function int unsigned first_hit(logic [31:0] code);
            for (int unsigned i = 0; i < entry_total; i++)
                if (entry_code[i] == code) return i;
            return entry_total;
        endfunction

        // work out the result of one accepted request word
        function void log_request(logic [2:0] op, logic [31:0] icode, logic [31:0] ipay,
                                  logic [31:0] tcode);
            t_list_result r;
            int unsigned  pos;
            bit           was_full;
            was_full  = (entry_total >= bsl_pkg::CAPACITY);
            r.status  = bsl_pkg::ST_OK;
            r.code    = '0;
            r.payload = '0;
            case (op)
                bsl_pkg::OP_APPEND: begin
                    if (was_full) r.status = bsl_pkg::ST_FULL;
                    else insert_at(entry_total, icode, ipay);
                end
                bsl_pkg::OP_PREPEND: begin
                    if (was_full) r.status = bsl_pkg::ST_FULL;
                    else insert_at(0, icode, ipay);
                end
                bsl_pkg::OP_POP_END: begin
                    if (entry_total == 0) begin
                        r.status = bsl_pkg::ST_EMPTY;
                    end else begin
                        r.code    = entry_code[entry_total - 1];
                        r.payload = entry_payload[entry_total - 1];
                        entry_total--;
                    end
                end
                bsl_pkg::OP_POP_FRONT: begin
                    if (entry_total == 0) begin
                        r.status = bsl_pkg::ST_EMPTY;
                    end else begin
                        r.code    = entry_code[0];
                        r.payload = entry_payload[0];
                        remove_at(0);
                    end
                end
                bsl_pkg::OP_FIND: begin
                    pos = first_hit(tcode);
                    if (pos >= entry_total) begin
                        r.status = bsl_pkg::ST_NOTFOUND;
                    end else begin
                        r.code    = entry_code[pos];
                        r.payload = entry_payload[pos];
                    end
                end
                bsl_pkg::OP_REMOVE: begin
                    if (entry_total == 0) begin
                        r.status = bsl_pkg::ST_EMPTY;
                    end else begin
                        // last match wins
                        pos = entry_total;
                        for (int unsigned i = 0; i < entry_total; i++)
                            if (entry_code[i] == tcode) pos = i;
                        if (pos >= entry_total) begin
                            r.status = bsl_pkg::ST_NOTFOUND;
                        end else begin
                            r.code    = entry_code[pos];
                            r.payload = entry_payload[pos];
                            remove_at(pos);
                        end
                    end
                end
                bsl_pkg::OP_INS_BEFORE: begin
                    // full test comes ahead of the empty test
                    if (was_full) begin
                        r.status = bsl_pkg::ST_FULL;
                    end else if (entry_total == 0) begin
                        r.status = bsl_pkg::ST_EMPTY;
                    end else begin
                        pos = first_hit(tcode);
                        if (pos >= entry_total) r.status = bsl_pkg::ST_NOTFOUND;
                        else insert_at(pos, icode, ipay);
                    end
                end
                default: begin
                end
            endcase
            r.entries = entry_total[4:0];
            r.full    = (entry_total == bsl_pkg::CAPACITY);
            r.empty   = (entry_total == 0);
            status_seen[r.status]++;
            if (r.full) full_seen++;
            owed_results.push_back(r);
        endfunction

        task report(string field, logic [31:0] got, logic [31:0] want);
            mismatches++;
            if (mismatches <= PRINT_CAP)
                $display("check failed at result %0d: %s got %h expected %h",
                         checked, field, got, want);
        endtask

        // compare one result word against the oldest owed result
        task check_response(logic [71:0] data, logic [1:0] status);
            t_list_result e;
            if (owed_results.size() == 0) begin
                report("unexpected result word", data[31:0], '0);
                return;
            end
            e = owed_results.pop_front();
            checked++;
            if (status !== e.status)
                report("status", 32'(status), 32'(e.status));
            if (data[31:0] !== e.code)
                report("out_code", data[31:0], e.code);
            if (data[63:32] !== e.payload)
                report("out_payload", data[63:32], e.payload);
            if (data[68:64] !== e.entries)
                report("entry_count", 32'(data[68:64]), 32'(e.entries));
            if (data[69] !== e.full)
                report("is_full", 32'(data[69]), 32'(e.full));
            if (data[70] !== e.empty)
                report("is_empty", 32'(data[70]), 32'(e.empty));
            if (data[71] !== 1'b0)
                report("pad bit", 32'(data[71]), 32'h0);
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [95:0] i_s_axis_tdata;    // item_code, item_payload, target_code
    logic [2:0]  i_s_axis_tuser;    // op
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [71:0] o_m_axis_tdata;    // out_code, out_payload, entry_count, is_full, is_empty
    logic [1:0]  o_m_axis_tuser;    // status

    t_list_mirror mirror;
    bit          quiet    = 0;
    bit          hold_req = 0;
    int unsigned stall_cycles = 0;

    bounded_sequential_list_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // note accepted requests, then check results, in one fixed order per edge
    always @(posedge i_clk) begin
        if (i_rst_n && i_s_axis_tvalid && o_s_axis_tready)
            mirror.log_request(i_s_axis_tuser, i_s_axis_tdata[31:0], i_s_axis_tdata[63:32],
                               i_s_axis_tdata[95:64]);
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            mirror.check_response(o_m_axis_tdata, o_m_axis_tuser);
    end

    // watchdog on cycles without any word moving
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
                $display("bounded_sequential_list_core: mismatch");
                $finish;
            end
        end
    end

    // result side: random stall bursts plus one long hold-off on request
    initial begin
        int unsigned stall_left;
        int unsigned run_left;
        bit          hold_done;
        stall_left      = 0;
        run_left        = 0;
        hold_done       = 0;
        i_m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req && !hold_done) begin
                stall_left = HOLD_CYCLES;
                hold_done  = 1;
            end else if (stall_left == 0 && run_left == 0) begin
                if (!quiet && $urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 10);
                else run_left = $urandom_range(1, 30);
            end
            if (stall_left != 0) begin
                i_m_axis_tready = 1'b0;
                stall_left--;
            end else begin
                i_m_axis_tready = 1'b1;
                if (run_left != 0) run_left--;
            end
        end
    end

    task automatic idle_cycles(int unsigned n);
        repeat (n) begin
            @(negedge i_clk);
            i_s_axis_tvalid = 1'b0;
        end
    endtask

    // offer one request word and wait for it to be taken
    task automatic send_item(logic [2:0] op, logic [31:0] icode, logic [31:0] ipay,
                             logic [31:0] tcode);
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tdata  = {tcode, ipay, icode};
        i_s_axis_tuser  = op;
        forever begin
            @(posedge i_clk);
            if (o_s_axis_tready) break;
        end
    endtask

    // small pool of codes so that matches and duplicates are common
    function automatic logic [31:0] pick_code();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h0000_0000;
            4, 5, 6: return 32'($urandom_range(1, 6));
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [31:0] pick_payload();
        case ($urandom_range(0, 15))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    // mostly a code that sits in the list right now
    function automatic logic [31:0] pick_target();
        if (mirror.entry_total != 0 && $urandom_range(0, 9) < 6)
            return mirror.entry_code[$urandom_range(0, mirror.entry_total - 1)];
        return pick_code();
    endfunction

    // op mix per phase: growing, shrinking or uniform
    function automatic logic [2:0] next_op(int unsigned mode);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (mode == 0) begin
            if (r < 30) return bsl_pkg::OP_APPEND;
            if (r < 50) return bsl_pkg::OP_PREPEND;
            if (r < 70) return bsl_pkg::OP_INS_BEFORE;
            if (r < 78) return bsl_pkg::OP_FIND;
            if (r < 83) return bsl_pkg::OP_POP_END;
            if (r < 88) return bsl_pkg::OP_POP_FRONT;
            if (r < 94) return bsl_pkg::OP_REMOVE;
            return bsl_pkg::OP_STATUS;
        end else if (mode == 1) begin
            if (r < 8)  return bsl_pkg::OP_APPEND;
            if (r < 12) return bsl_pkg::OP_PREPEND;
            if (r < 16) return bsl_pkg::OP_INS_BEFORE;
            if (r < 26) return bsl_pkg::OP_FIND;
            if (r < 46) return bsl_pkg::OP_POP_END;
            if (r < 66) return bsl_pkg::OP_POP_FRONT;
            if (r < 92) return bsl_pkg::OP_REMOVE;
            return bsl_pkg::OP_STATUS;
        end
        return 3'($urandom_range(0, 7));
    endfunction

    // stimulus
    initial begin
        int unsigned mode;
        int unsigned gap_pct;
        int unsigned phase_left;
        logic [2:0]  op;
        logic [31:0] icode;
        logic [31:0] ipay;
        logic [31:0] tcode;
        mirror          = new();
        mode            = 2;
        gap_pct         = 0;
        phase_left      = 0;
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = bsl_pkg::OP_STATUS;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // empty list corner cases
        send_item(bsl_pkg::OP_STATUS,     32'h0, 32'h0, 32'h0);
        send_item(bsl_pkg::OP_POP_END,    32'h0, 32'h0, 32'h0);
        send_item(bsl_pkg::OP_POP_FRONT,  32'h0, 32'h0, 32'h0);
        send_item(bsl_pkg::OP_REMOVE,     32'h0, 32'h0, 32'h0);
        send_item(bsl_pkg::OP_FIND,       32'h0, 32'h0, 32'h0);
        send_item(bsl_pkg::OP_INS_BEFORE, 32'h1, 32'h1, 32'h0);
        // extreme codes and payloads, then duplicate codes
        send_item(bsl_pkg::OP_APPEND,     32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(bsl_pkg::OP_PREPEND,    32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF);
        send_item(bsl_pkg::OP_APPEND,     32'h5, 32'h3F80_0000, 32'h0);
        send_item(bsl_pkg::OP_APPEND,     32'h5, 32'h4000_0000, 32'h0);
        send_item(bsl_pkg::OP_FIND,       32'h0, 32'h0, 32'h5);
        send_item(bsl_pkg::OP_FIND,       32'h0, 32'h0, 32'h9);
        send_item(bsl_pkg::OP_INS_BEFORE, 32'hFFFF_FFFF, 32'h7F80_0000, 32'h5);
        send_item(bsl_pkg::OP_INS_BEFORE, 32'h3, 32'h3, 32'h7B);
        send_item(bsl_pkg::OP_REMOVE,     32'h0, 32'h0, 32'h5);
        send_item(bsl_pkg::OP_REMOVE,     32'h0, 32'h0, 32'h4D);
        send_item(bsl_pkg::OP_STATUS,     32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(bsl_pkg::OP_POP_END,    32'h0, 32'h0, 32'h0);
        send_item(bsl_pkg::OP_POP_FRONT,  32'h0, 32'h0, 32'h0);
        send_item(bsl_pkg::OP_FIND,       32'h0, 32'h0, 32'h8000_0000);

        // random phases that fill, drain or mix the list
        for (int unsigned k = 0; k < RANDOM_ITEMS; k++) begin
            if (phase_left == 0) begin
                mode       = $urandom_range(0, 2);
                gap_pct    = ($urandom_range(0, 2) == 0) ? 0 : 25;
                phase_left = $urandom_range(40, 120);
            end
            phase_left--;
            if (k == HOLD_AT) hold_req = 1;
            if (k >= RANDOM_ITEMS - QUIET_TAIL) quiet = 1;
            op    = next_op(mode);
            icode = pick_code();
            ipay  = pick_payload();
            tcode = pick_target();
            if (!quiet && $urandom_range(0, 99) < gap_pct) idle_cycles($urandom_range(1, 10));
            send_item(op, icode, ipay, tcode);
        end
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;

        // let the last results drain
        while (mirror.owed_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("run covered %0d words: %0d ok, %0d full, %0d empty, %0d not found",
                 mirror.checked, mirror.status_seen[bsl_pkg::ST_OK],
                 mirror.status_seen[bsl_pkg::ST_FULL],
                 mirror.status_seen[bsl_pkg::ST_EMPTY],
                 mirror.status_seen[bsl_pkg::ST_NOTFOUND]);
        $display("list at capacity after %0d operations, %0d field errors",
                 mirror.full_seen, mirror.mismatches);
        if (mirror.mismatches == 0)
            $display("bounded_sequential_list_core: match");
        else
            $display("bounded_sequential_list_core: mismatch");
        $finish;
    end

endmodule
